[design/ntl_pkg.sv]
package ntl_pkg;

  localparam int TABLE_ENTRIES_DEF = 33;
  localparam int ADC_BITS_DEF      = 12;
  localparam int TAB_IW            = 6;
  localparam int TAB_W             = 18;
  localparam int IDX_W             = 6;
  localparam int RES_W             = 32;
  localparam int TEMP_W            = 24;
  localparam int SER_W             = 16;
  localparam int OUT_DATA_W        = 64;

  localparam logic [SER_W-1:0] SERIES_RESET = 16'd5080;
  localparam logic [31:0]      STEP_TEMP    = 32'd327680;
  localparam logic [31:0]      BASE_TEMP    = 32'hFFD80000;
  localparam logic [31:0]      R_OFFSET     = 32'h00010000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_R,
    OP_RES,
    OP_SEARCH,
    OP_DIFF,
    OP_DIV_S,
    OP_MUL_T,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic div_done;
    logic search_done;
    logic in_range;
    logic diff_zero;
  } dp_stat_t;

  function automatic logic [TAB_W-1:0] table_res(input logic [TAB_IW-1:0] i);
    logic [TAB_W-1:0] v;
    case (i)
      6'd0:  v = 18'd195652;
      6'd1:  v = 18'd148171;
      6'd2:  v = 18'd113347;
      6'd3:  v = 18'd87559;
      6'd4:  v = 18'd68237;
      6'd5:  v = 18'd53650;
      6'd6:  v = 18'd42506;
      6'd7:  v = 18'd33892;
      6'd8:  v = 18'd27219;
      6'd9:  v = 18'd22021;
      6'd10: v = 18'd17926;
      6'd11: v = 18'd14674;
      6'd12: v = 18'd12081;
      6'd13: v = 18'd10000;
      6'd14: v = 18'd8315;
      6'd15: v = 18'd6948;
      6'd16: v = 18'd5834;
      6'd17: v = 18'd4917;
      6'd18: v = 18'd4161;
      6'd19: v = 18'd3535;
      6'd20: v = 18'd3014;
      6'd21: v = 18'd2586;
      6'd22: v = 18'd2228;
      6'd23: v = 18'd1925;
      6'd24: v = 18'd1669;
      6'd25: v = 18'd1452;
      6'd26: v = 18'd1268;
      6'd27: v = 18'd1110;
      6'd28: v = 18'd974;
      6'd29: v = 18'd858;
      6'd30: v = 18'd758;
      6'd31: v = 18'd671;
      6'd32: v = 18'd596;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/ntl_div.sv]
module ntl_div
  import ntl_pkg::*;
#(
  parameter int NW = ADC_BITS_DEF + 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic          done,
  output logic [31:0]   quot
);

  localparam int CNTW = $clog2(NW);

  logic [31:0]     q_r, q_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [NW-1:0]   num_r, num_nxt;
  logic [31:0]     den_r, den_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [32:0]     trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], num_r[NW-1]};
    if (start) begin
      q_nxt    = '0;
      rem_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      if (cnt_r == CNTW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[design/ntl_datapath.sv]
module ntl_datapath
  import ntl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int ADC_BITS      = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [ADC_BITS-1:0]   adc_counts,
  input  logic                  cfg_wr_en,
  input  logic [SER_W-1:0]      cfg_wr_data,
  output logic [RES_W-1:0]      resistance_ohms,
  output logic [IDX_W-1:0]      table_index,
  output logic                  in_range,
  output logic [TEMP_W-1:0]     temperature
);

  localparam int NW = ADC_BITS + 17;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [SER_W-1:0]    series_r;
  logic [ADC_BITS-1:0] cnt_r;
  logic [15:0]         res_r;
  logic [CW-1:0]       idx_r;
  logic [TAB_W-1:0]    diff_r;
  logic [31:0]         hr_r;
  logic [31:0]         mt_r;
  logic [RES_W-1:0]    ores_r;
  logic [IDX_W-1:0]    oidx_r;
  logic                oinr_r;
  logic [TEMP_W-1:0]   otemp_r;

  logic                div_start;
  logic [NW-1:0]       div_num;
  logic [31:0]         div_den;
  logic                div_done;
  logic [31:0]         quot;
  logic [31:0]         rq;
  logic [31:0]         prod;
  logic [TAB_W-1:0]    t_cur;
  logic [TAB_W-1:0]    t_prev;
  logic [CW-1:0]       idx_m1;
  logic                cont;
  logic                inr;
  logic [31:0]         slope;
  logic [31:0]         sum;

  assign div_start = (cmd.op == OP_DIV_R) || (cmd.op == OP_DIV_S);
  assign div_num   = (cmd.op == OP_DIV_S) ? NW'(STEP_TEMP) : (NW'(1) << (ADC_BITS + 16));
  assign div_den   = (cmd.op == OP_DIV_S) ? 32'(diff_r) : 32'(cnt_r);

  ntl_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  assign rq     = quot - R_OFFSET;
  assign prod   = rq * 32'(series_r);
  assign idx_m1 = idx_r - 1'b1;
  assign t_cur  = table_res(TAB_IW'(idx_r));
  assign t_prev = table_res(TAB_IW'(idx_m1));
  assign cont   = (idx_r < CW'(TABLE_ENTRIES)) && (t_cur >= TAB_W'(res_r));
  assign inr    = (idx_r >= CW'(1)) && (idx_r < CW'(TABLE_ENTRIES));
  assign slope  = (diff_r == '0) ? 32'd0 : quot;
  assign sum    = mt_r + BASE_TEMP + STEP_TEMP * 32'(idx_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= SERIES_RESET;
    end else if (cfg_wr_en) begin
      series_r <= cfg_wr_data;
    end
    case (cmd.op)
      OP_LOAD:   cnt_r <= adc_counts;
      OP_RES: begin
        res_r <= prod[31:16];
        idx_r <= '0;
      end
      OP_SEARCH: idx_r <= idx_r + 1'b1;
      OP_DIFF: begin
        diff_r <= t_prev - t_cur;
        hr_r   <= 32'(t_prev) - 32'(res_r);
      end
      OP_MUL_T:  mt_r <= slope * hr_r;
      OP_OUT: begin
        ores_r  <= RES_W'(res_r);
        oidx_r  <= IDX_W'(idx_r);
        oinr_r  <= inr;
        otemp_r <= inr ? sum[TEMP_W-1:0] : '0;
      end
      default: ;
    endcase
  end

  assign stat.count_zero  = (cnt_r == '0);
  assign stat.div_done    = div_done;
  assign stat.search_done = !cont;
  assign stat.in_range    = inr;
  assign stat.diff_zero   = (diff_r == '0);

  assign resistance_ohms = ores_r;
  assign table_index     = oidx_r;
  assign in_range        = oinr_r;
  assign temperature     = otemp_r;

endmodule

[design/ntl_ctrl.sv]
module ntl_ctrl
  import ntl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVR,
    S_SEARCH,
    S_DIFF,
    S_DIVS,
    S_MUL,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.count_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_DIV_R;
          state_nxt = S_DIVR;
        end
      end
      S_DIVR: begin
        if (stat.div_done) begin
          cmd.op    = OP_RES;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!stat.search_done) begin
          cmd.op = OP_SEARCH;
        end else if (stat.in_range) begin
          cmd.op    = OP_DIFF;
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIFF: begin
        if (stat.diff_zero) begin
          state_nxt = S_MUL;
        end else begin
          cmd.op    = OP_DIV_S;
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        if (stat.div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL_T;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted item did not move to count check");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while held");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> ((state_r == S_DIVR) || (state_r == S_DIVS)))
    else $error("divider finished outside a divide state");

  a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> out_tvalid)
    else $error("result loaded without valid");
`endif

endmodule

[design/ntc_thermistor_linearizer.sv]
// channel   signals                    contents (lsb first)
// in        in_tvalid/tready/tdata     adc_counts
// out       out_tvalid/tready/tdata    resistance_ohms, table_index, temperature
//           out_tuser                  in_range
// cfg       cfg_wr_en/cfg_wr_data      series_ohms
//
// Zero count: no item out. Otherwise the result comes from the shared bit-serial divider
// (resistance, then slope) and the one-entry-a-cycle table search; out of range skips the
// slope divide.
// Synchronous active-low reset; series_ohms resets to 5080.
// A held output item does not block the next accept; the block waits only to load a new result.
module ntc_thermistor_linearizer
  import ntl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int ADC_BITS      = ADC_BITS_DEF,
  parameter int IN_DATA_W     = ((ADC_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // adc_counts
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // resistance_ohms, table_index, temperature
  output logic                  out_tuser,  // in_range
  input  logic                  cfg_wr_en,
  input  logic [SER_W-1:0]      cfg_wr_data
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [RES_W-1:0]  resistance_ohms;
  logic [IDX_W-1:0]  table_index;
  logic [TEMP_W-1:0] temperature;

  ntl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ntl_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADC_BITS      (ADC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .adc_counts      (in_tdata[ADC_BITS-1:0]),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .resistance_ohms (resistance_ohms),
    .table_index     (table_index),
    .in_range        (out_tuser),
    .temperature     (temperature)
  );

  assign out_tdata = {{(OUT_DATA_W - RES_W - IDX_W - TEMP_W){1'b0}},
                      temperature, table_index, resistance_ohms};

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ntl_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int MAX_CYCLES = 1000000;
  localparam int SETTLE     = 120;
  localparam int LONG_HOLD  = 400;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 150;

  localparam int unsigned RES_OHMS [TABLE_ENTRIES_DEF] = '{
    195652, 148171, 113347, 87559, 68237, 53650, 42506, 33892,
    27219, 22021, 17926, 14674, 12081, 10000, 8315, 6948,
    5834, 4917, 4161, 3535, 3014, 2586, 2228, 1925,
    1669, 1452, 1268, 1110, 974, 858, 758, 671,
    596
  };

  typedef struct {
    logic [RES_W-1:0]         resistance;
    logic [IDX_W-1:0]         index;
    logic                     in_range;
    logic signed [TEMP_W-1:0] temperature;
  } reading_t;

  class linearizer_scoreboard;
    reading_t         pending_readings[$];
    logic [SER_W-1:0] series_ohms;
    int               mismatches;

    function new();
      series_ohms = SERIES_RESET;
      mismatches  = 0;
    endfunction

    function reading_t convert_count(logic [11:0] count);
      reading_t   rd;
      logic [31:0] r;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] slope;
      logic [31:0] t;
      int          idx;
      r = 32'h1000_0000 / {20'd0, count};
      r = r - R_OFFSET;
      r = r * {16'd0, series_ohms};
      r = r >> 16;
      idx = 0;
      while (idx < TABLE_ENTRIES_DEF && RES_OHMS[idx] >= r) idx++;
      t = '0;
      rd.in_range = 1'b0;
      if (idx >= 1 && idx < TABLE_ENTRIES_DEF) begin
        hi = RES_OHMS[idx-1];
        lo = RES_OHMS[idx];
        slope = (hi != lo) ? STEP_TEMP / (hi - lo) : '0;
        t = slope * (hi - r) + (BASE_TEMP + STEP_TEMP * 32'(idx - 1));
        rd.in_range = 1'b1;
      end
      rd.resistance  = r;
      rd.index       = IDX_W'(idx);
      rd.temperature = t[TEMP_W-1:0];
      return rd;
    endfunction

    function void note_count(logic [11:0] count);
      if (count != 0) pending_readings.push_back(convert_count(count));
    endfunction

    function void check_reading(logic [OUT_DATA_W-1:0] data, logic user);
      reading_t exp_rd;
      if (pending_readings.size() == 0) begin
        $error("unexpected item: tdata=%h tuser=%b", data, user);
        mismatches++;
        return;
      end
      exp_rd = pending_readings.pop_front();
      if (data[31:0] !== exp_rd.resistance) begin
        $error("resistance_ohms: expected %0d, actual %0d", exp_rd.resistance, data[31:0]);
        mismatches++;
      end
      if (data[37:32] !== exp_rd.index) begin
        $error("table_index: expected %0d, actual %0d", exp_rd.index, data[37:32]);
        mismatches++;
      end
      if (data[61:38] !== exp_rd.temperature) begin
        $error("temperature: expected %h, actual %h", exp_rd.temperature, data[61:38]);
        mismatches++;
      end
      if (data[63:62] !== 2'b00) begin
        $error("tdata padding: expected 0, actual %b", data[63:62]);
        mismatches++;
      end
      if (user !== exp_rd.in_range) begin
        $error("in_range: expected %b, actual %b", exp_rd.in_range, user);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [SER_W-1:0]      cfg_wr_data = '0;

  linearizer_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int cycles = 0;

  ntc_thermistor_linearizer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reading(out_tdata, out_tuser);
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_count(input logic [11:0] count);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'd0, count};
    do @(posedge clk); while (!in_tready);
    sb.note_count(count);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_series(input logic [SER_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.series_ohms = value;
  endtask

  function automatic logic [11:0] random_count();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 12'd0;
    if (sel < 15) return 12'($urandom_range(1, 120));
    if (sel < 22) return 12'($urandom_range(3600, 4095));
    return 12'($urandom_range(1, 4095));
  endfunction

  logic [11:0]      directed_counts [20] = '{
    12'd1, 12'd4095, 12'd0, 12'd50, 12'd103, 12'd104, 12'd4000, 12'd3667,
    12'd2048, 12'd1024, 12'hAAA, 12'h555, 12'd0, 12'd300, 12'd1500, 12'd3000,
    12'd3500, 12'd3700, 12'd2, 12'd700
  };
  logic [SER_W-1:0] series_steps [NUM_PHASES] = '{
    16'd65535, 16'd0, 16'd1, 16'd10000, 16'd5080, 16'd5080
  };

  initial begin
    int          sent;
    logic [11:0] count;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_counts[i]) send_count(directed_counts[i]);
    drain_and_settle();

    series_steps[4] = 16'($urandom_range(0, 65535));
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_series(series_steps[phase]);
      calm = (phase == NUM_PHASES - 1);
      if (phase == 3) hold_request = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        count = random_count();
        send_count(count);
        if (count != 0) sent++;
      end
      drain_and_settle();
    end

    if (sb.mismatches == 0 && sb.pending_readings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
